@@ src/hmb_pkg.sv @@
// ============================================================================
// hmb_pkg
// Shared constants, types and the I/O default table of the memory bus.
// ============================================================================
package hmb_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int DMA_LENGTH = 160;
    localparam int DMA_CNT_W  = $clog2(DMA_LENGTH + 1);

    localparam logic [1:0] REQ_CPU_READ  = 2'd0;
    localparam logic [1:0] REQ_CPU_WRITE = 2'd1;
    localparam logic [1:0] REQ_PPU_READ  = 2'd2;
    localparam logic [1:0] REQ_ROM_LOAD  = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_DMA     = 2'd3;

    localparam logic [1:0] MODE_OAM_SCAN = 2'd2;
    localparam logic [1:0] MODE_DRAWING  = 2'd3;

    localparam logic [ADDR_W-1:0] ADDR_VRAM_LO = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_VRAM_HI = 16'h97FF;
    localparam logic [ADDR_W-1:0] ADDR_OAM_LO  = 16'hFE00;
    localparam logic [ADDR_W-1:0] ADDR_OAM_HI  = 16'hFE9F;
    localparam logic [ADDR_W-1:0] ADDR_DIV     = 16'hFF04;
    localparam logic [ADDR_W-1:0] ADDR_LY      = 16'hFF44;
    localparam logic [ADDR_W-1:0] ADDR_DMA     = 16'hFF46;
    localparam logic [ADDR_W-1:0] ADDR_PAL_LO  = 16'hFF47;
    localparam logic [ADDR_W-1:0] ADDR_PAL_HI  = 16'hFF49;
    localparam logic [7:0]        IO_PAGE      = 8'hFF;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic exec;
        logic read_resp;
        logic dma_step;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic need_read;
        logic is_dma;
        logic dma_last;
    } dp_stat_t;

    function automatic logic [DATA_W-1:0] io_default(input logic [7:0] off);
        logic [DATA_W-1:0] v;
        case (off)
            8'h00: v = 8'h3F;
            8'h02: v = 8'h7E;
            8'h04: v = 8'h18;
            8'h07: v = 8'hF8;
            8'h0F: v = 8'hE1;
            8'h10: v = 8'h80;
            8'h11: v = 8'hBF;
            8'h12: v = 8'hF3;
            8'h13: v = 8'hFF;
            8'h14: v = 8'hBF;
            8'h16: v = 8'h3F;
            8'h18: v = 8'hFF;
            8'h19: v = 8'hBF;
            8'h1A: v = 8'h7F;
            8'h1B: v = 8'hFF;
            8'h1C: v = 8'h9F;
            8'h1D: v = 8'hFF;
            8'h1E: v = 8'hBF;
            8'h20: v = 8'hFF;
            8'h23: v = 8'hBF;
            8'h24: v = 8'h77;
            8'h25: v = 8'hF3;
            8'h26: v = 8'hF1;
            8'h40: v = 8'h91;
            8'h41: v = 8'h81;
            8'h44: v = 8'h91;
            8'h46: v = 8'hFF;
            8'h47: v = 8'hFC;
            8'h4D: v = 8'h7E;
            8'h4F: v = 8'hFE;
            8'h50: v = 8'hFF;
            8'h51: v = 8'hFF;
            8'h52: v = 8'hFF;
            8'h53: v = 8'hFF;
            8'h54: v = 8'hFF;
            8'h55: v = 8'hFF;
            8'h56: v = 8'h3E;
            8'h70: v = 8'hF8;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

@@ src/hmb_ram.sv @@
// ============================================================================
// hmb_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module hmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/hmb_dp.sv @@
// ============================================================================
// hmb_dp
// Datapath: request registers, access decode, holding byte, clear and DMA
// counters, the bus memory and the result registers.
// ============================================================================
module hmb_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  hmb_pkg::dp_cmd_t  cmd,
    output hmb_pkg::dp_stat_t stat,
    input  logic [1:0]        req_type,
    input  logic [15:0]       addr,
    input  logic [7:0]        wdata,
    input  logic [1:0]        ppu_mode,
    output logic              done,
    output logic [7:0]        rdata,
    output logic [1:0]        status
);

    import hmb_pkg::*;

    logic [1:0]           req_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [DATA_W-1:0]    wdata_reg;
    logic [1:0]           mode_reg;
    logic [DATA_W-1:0]    hold_reg;
    logic [DATA_W-1:0]    hold_next;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic [DMA_CNT_W-1:0] dma_cnt_reg;
    logic [DATA_W-1:0]    rdata_reg;
    logic [DATA_W-1:0]    rdata_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic                 done_reg;
    logic                 done_next;

    logic                 allowed;
    logic                 protected_addr;
    logic                 is_cpu_read;
    logic                 is_cpu_write;
    logic                 is_dma_write;
    logic                 need_read;
    logic                 exec_write;
    logic                 refresh;
    logic [1:0]           exec_status;
    logic [DATA_W-1:0]    exec_rdata;
    logic [DATA_W-1:0]    exec_wdata;

    logic [ADDR_W-1:0]    dma_src;
    logic [ADDR_W-1:0]    dma_dst;
    logic                 dma_last;
    logic [DATA_W-1:0]    clr_data;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [DATA_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [DATA_W-1:0]    ram_q;

    always_comb
    begin
        allowed = 1'b1;
        if ((mode_reg == MODE_OAM_SCAN || mode_reg == MODE_DRAWING)
            && addr_reg >= ADDR_OAM_LO && addr_reg <= ADDR_OAM_HI)
        begin
            allowed = 1'b0;
        end
        if (mode_reg == MODE_DRAWING
            && ((addr_reg >= ADDR_VRAM_LO && addr_reg <= ADDR_VRAM_HI)
                || (addr_reg >= ADDR_PAL_LO && addr_reg <= ADDR_PAL_HI)))
        begin
            allowed = 1'b0;
        end
    end

    assign protected_addr = (addr_reg == ADDR_LY) || (addr_reg < ADDR_VRAM_LO);
    assign is_cpu_read    = (req_reg == REQ_CPU_READ);
    assign is_cpu_write   = (req_reg == REQ_CPU_WRITE);
    assign is_dma_write   = is_cpu_write && !protected_addr && (addr_reg == ADDR_DMA);
    assign refresh        = is_cpu_read && protected_addr;

    always_comb
    begin
        need_read   = 1'b0;
        exec_write  = 1'b0;
        exec_status = ST_DONE;
        exec_rdata  = '0;
        exec_wdata  = wdata_reg;
        case (req_reg)
            REQ_CPU_READ:
            begin
                if (allowed)
                begin
                    need_read = 1'b1;
                end
                else
                begin
                    exec_status = ST_BLOCKED;
                    exec_rdata  = hold_reg;
                end
            end
            REQ_CPU_WRITE:
            begin
                if (protected_addr)
                begin
                    exec_status = ST_IGNORED;
                end
                else if (is_dma_write)
                begin
                    exec_write  = 1'b1;
                    exec_status = ST_DMA;
                end
                else if (allowed)
                begin
                    exec_write = 1'b1;
                    if (addr_reg == ADDR_DIV)
                    begin
                        exec_wdata = '0;
                    end
                end
                else
                begin
                    exec_status = ST_BLOCKED;
                end
            end
            REQ_PPU_READ:
            begin
                need_read = 1'b1;
            end
            REQ_ROM_LOAD:
            begin
                exec_write = 1'b1;
            end
            default:
            begin
                need_read = 1'b0;
            end
        endcase
    end

    assign dma_src  = {wdata_reg, 8'h00} + ADDR_W'(dma_cnt_reg);
    assign dma_dst  = ADDR_OAM_LO + ADDR_W'(dma_cnt_reg) - ADDR_W'(1);
    assign dma_last = (dma_cnt_reg == DMA_CNT_W'(DMA_LENGTH));
    assign clr_data = (clr_cnt_reg[ADDR_W-1:8] == IO_PAGE) ? io_default(clr_cnt_reg[7:0]) : '0;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = exec_wdata;
        ram_raddr = addr_reg;
        if (cmd.clear_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = clr_data;
        end
        else if (cmd.exec)
        begin
            ram_we = exec_write;
        end
        else if (cmd.dma_step)
        begin
            ram_we    = (dma_cnt_reg != '0);
            ram_waddr = dma_dst;
            ram_wdata = ram_q;
            ram_raddr = dma_src;
        end
    end

    hmb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        done_next   = 1'b0;
        rdata_next  = rdata_reg;
        status_next = status_reg;
        hold_next   = hold_reg;
        if (cmd.exec && !need_read && !is_dma_write)
        begin
            done_next   = 1'b1;
            rdata_next  = exec_rdata;
            status_next = exec_status;
        end
        else if (cmd.read_resp)
        begin
            done_next   = 1'b1;
            rdata_next  = ram_q;
            status_next = ST_DONE;
            if (refresh)
            begin
                hold_next = ram_q;
            end
        end
        else if (cmd.dma_step && dma_last)
        begin
            done_next   = 1'b1;
            rdata_next  = '0;
            status_next = ST_DMA;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type;
            addr_reg  <= addr;
            wdata_reg <= wdata;
            mode_reg  <= ppu_mode;
        end
        rdata_reg  <= rdata_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg    <= 8'hFF;
            clr_cnt_reg <= '0;
            dma_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
            done_reg <= done_next;
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.exec)
            begin
                dma_cnt_reg <= '0;
            end
            else if (cmd.dma_step)
            begin
                dma_cnt_reg <= dma_cnt_reg + DMA_CNT_W'(1);
            end
        end
    end

    assign stat.clr_last  = &clr_cnt_reg;
    assign stat.need_read = need_read;
    assign stat.is_dma    = is_dma_write;
    assign stat.dma_last  = dma_last;

    assign done   = done_reg;
    assign rdata  = rdata_reg;
    assign status = status_reg;

endmodule

@@ src/hmb_ctrl.sv @@
// ============================================================================
// hmb_ctrl
// Controller: sequences the memory clear, request execution, read response
// and the OAM DMA copy.
// ============================================================================
module hmb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output hmb_pkg::dp_cmd_t  cmd,
    input  hmb_pkg::dp_stat_t stat
);

    import hmb_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DMA   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.need_read)
                begin
                    state_next = S_READ;
                end
                else if (stat.is_dma)
                begin
                    state_next = S_DMA;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            S_DMA:
            begin
                if (stat.dma_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign cmd.clear_step = (state_reg == S_CLEAR);
    assign cmd.load       = (state_reg == S_IDLE) && start;
    assign cmd.exec       = (state_reg == S_EXEC);
    assign cmd.read_resp  = (state_reg == S_READ);
    assign cmd.dma_step   = (state_reg == S_DMA);

endmodule

@@ src/handheld_memory_bus_with_oam_dma.sv @@
// ============================================================================
// handheld_memory_bus_with_oam_dma
// 64 KiB byte bus with video-mode access rules and OAM DMA.
// ============================================================================
// A request is taken at a rising edge where start is high and busy is low.
// Its fields are req_type, addr, wdata and ppu_mode.
// Each request gives one result: done is high for one cycle while rdata and
// status hold it, and the receiver cannot hold results off.
// Writes, ignored writes and refused reads are settled in the execute state;
// reads of memory go on to a read state. Each result is registered.
// The read path goes through one registered port of the 64 KiB memory.
// A write to the DMA register copies DMA_LENGTH bytes into OAM at one byte
// per cycle and gives its result when the copy ends.
// Busy stays high until the result is shown; the next request can be taken
// in the cycle that shows it.
// After reset the memory is swept to its reset contents, one byte per cycle,
// with busy high; the holding byte resets to 0xFF.
// ============================================================================
module handheld_memory_bus_with_oam_dma (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [15:0] addr,
    input  logic [7:0]  wdata,
    input  logic [1:0]  ppu_mode,
    output logic        done,
    output logic [7:0]  rdata,
    output logic [1:0]  status
);

    import hmb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    hmb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    hmb_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .req_type (req_type),
        .addr     (addr),
        .wdata    (wdata),
        .ppu_mode (ppu_mode),
        .done     (done),
        .rdata    (rdata),
        .status   (status)
    );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the handheld memory bus with OAM DMA.
// Every request is also applied to a shadow memory and holding byte kept in
// the bench, and the result that this shadow predicts is queued. Each result
// strobed on done is compared with the oldest queued prediction. Directed
// requests cover the reset contents, the holding byte, the write rules, the
// mode locks and DMA. Random traffic and DMA sequences follow.
// ============================================================================
module tb;

    import hmb_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int REPORT_MAX  = 10;

    // Offset in the high byte, reset value in the low byte.
    localparam logic [38*16-1:0] IO_RESET_BYTES = {
        16'h003F, 16'h027E, 16'h0418, 16'h07F8, 16'h0FE1, 16'h1080, 16'h11BF,
        16'h12F3, 16'h13FF, 16'h14BF, 16'h163F, 16'h18FF, 16'h19BF, 16'h1A7F,
        16'h1BFF, 16'h1C9F, 16'h1DFF, 16'h1EBF, 16'h20FF, 16'h23BF, 16'h2477,
        16'h25F3, 16'h26F1, 16'h4091, 16'h4181, 16'h4491, 16'h46FF, 16'h47FC,
        16'h4D7E, 16'h4FFE, 16'h50FF, 16'h51FF, 16'h52FF, 16'h53FF, 16'h54FF,
        16'h55FF, 16'h563E, 16'h70F8
    };

    typedef struct packed {
        logic [7:0] rdata;
        logic [1:0] status;
    } bus_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        start    = 1'b0;
    logic        busy;
    logic [1:0]  req_type = REQ_CPU_READ;
    logic [15:0] addr     = '0;
    logic [7:0]  wdata    = '0;
    logic [1:0]  ppu_mode = '0;
    logic        done;
    logic [7:0]  rdata;
    logic [1:0]  status;

    logic [7:0]  shadow_mem [0:MEM_DEPTH-1];
    logic [7:0]  held_byte;
    bus_result_t expected_results [$];
    bit          sender_idles;
    int          error_count;
    int          report_count;
    int          cycle_count;

    handheld_memory_bus_with_oam_dma u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .addr     (addr),
        .wdata    (wdata),
        .ppu_mode (ppu_mode),
        .done     (done),
        .rdata    (rdata),
        .status   (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic bit cpu_allowed(logic [15:0] a, logic [1:0] m);
        if ((m == MODE_OAM_SCAN || m == MODE_DRAWING) && a >= ADDR_OAM_LO && a <= ADDR_OAM_HI)
            return 1'b0;
        if (m == MODE_DRAWING && a >= ADDR_VRAM_LO && a <= ADDR_VRAM_HI)
            return 1'b0;
        if (m == MODE_DRAWING && a >= ADDR_PAL_LO && a <= ADDR_PAL_HI)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic bus_result_t bus_access_model(logic [1:0] kind, logic [15:0] a,
                                                     logic [7:0] d, logic [1:0] m);
        bus_result_t r;
        logic [15:0] src_addr;
        logic [15:0] dst_addr;
        r.rdata  = 8'h00;
        r.status = ST_DONE;
        case (kind)
            REQ_CPU_READ:
            begin
                if (!cpu_allowed(a, m))
                begin
                    r.rdata  = held_byte;
                    r.status = ST_BLOCKED;
                end
                else
                begin
                    r.rdata = shadow_mem[a];
                    if (a < ADDR_VRAM_LO || a == ADDR_LY)
                        held_byte = r.rdata;
                end
            end
            REQ_CPU_WRITE:
            begin
                if (a == ADDR_LY || a < ADDR_VRAM_LO)
                    r.status = ST_IGNORED;
                else if (a == ADDR_DMA)
                begin
                    shadow_mem[a] = d;
                    for (int k = 0; k < DMA_LENGTH; k++)
                    begin
                        src_addr = {d, 8'h00} + 16'(k);
                        dst_addr = ADDR_OAM_LO + 16'(k);
                        shadow_mem[dst_addr] = shadow_mem[src_addr];
                    end
                    r.status = ST_DMA;
                end
                else if (cpu_allowed(a, m))
                    shadow_mem[a] = (a == ADDR_DIV) ? 8'h00 : d;
                else
                    r.status = ST_BLOCKED;
            end
            REQ_PPU_READ:
                r.rdata = shadow_mem[a];
            default:
                shadow_mem[a] = d;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] pick_address();
        logic [15:0] a;
        case ($urandom_range(0, 9))
            0, 1:    a = 16'($urandom);
            2:       a = 16'($urandom_range(0, 16'h7FFF));
            3:       a = 16'($urandom_range(ADDR_VRAM_LO, ADDR_VRAM_HI));
            4, 5:    a = 16'($urandom_range(ADDR_OAM_LO, ADDR_OAM_HI + 8));
            6, 7:    a = {IO_PAGE, 8'($urandom)};
            default:
            begin
                case ($urandom_range(0, 15))
                    0:       a = ADDR_VRAM_LO - 16'd1;
                    1:       a = ADDR_VRAM_LO;
                    2:       a = ADDR_VRAM_HI;
                    3:       a = ADDR_VRAM_HI + 16'd1;
                    4:       a = ADDR_OAM_LO - 16'd1;
                    5:       a = ADDR_OAM_LO;
                    6:       a = ADDR_OAM_HI;
                    7:       a = ADDR_OAM_HI + 16'd1;
                    8:       a = ADDR_DIV;
                    9:       a = ADDR_LY;
                    10:      a = ADDR_DMA;
                    11:      a = ADDR_PAL_LO;
                    12:      a = ADDR_PAL_HI;
                    13:      a = ADDR_PAL_HI + 16'd1;
                    14:      a = 16'hFFFF;
                    default: a = 16'h0000;
                endcase
            end
        endcase
        return a;
    endfunction

    always @(posedge clk)
    begin
        bus_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (report_count < REPORT_MAX)
                    $display("unexpected result: rdata %h status %0d", rdata, status);
                report_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (rdata !== want.rdata || status !== want.status)
                begin
                    error_count++;
                    if (report_count < REPORT_MAX)
                        $display("mismatch: rdata expected %h got %h, status expected %0d got %0d",
                                 want.rdata, rdata, want.status, status);
                    report_count++;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue_request(input logic [1:0] kind, input logic [15:0] a,
                                 input logic [7:0] d, input logic [1:0] m);
        if (sender_idles && $urandom_range(0, 99) < 23)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        req_type = kind;
        addr     = a;
        wdata    = d;
        ppu_mode = m;
        start    = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(bus_access_model(kind, a, d, m));
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic wait_results_drained();
        int guard;
        guard = 0;
        while (expected_results.size() != 0 && guard < 4 * DMA_LENGTH)
        begin
            @(negedge clk);
            guard++;
        end
    endtask

    task automatic apply_reset();
        logic [15:0] entry;
        for (int k = 0; k < MEM_DEPTH; k++)
            shadow_mem[k] = 8'h00;
        for (int k = 0; k < 38; k++)
        begin
            entry = IO_RESET_BYTES[k*16 +: 16];
            shadow_mem[{IO_PAGE, entry[15:8]}] = entry[7:0];
        end
        held_byte = 8'hFF;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
    endtask

    task automatic test_reset_contents();
        issue_request(REQ_PPU_READ, {IO_PAGE, 8'h00}, 8'h00, 2'd0);
        issue_request(REQ_PPU_READ, ADDR_LY, 8'h00, MODE_DRAWING);
        issue_request(REQ_PPU_READ, {IO_PAGE, 8'h70}, 8'h00, 2'd1);
        issue_request(REQ_PPU_READ, {IO_PAGE, 8'h71}, 8'h00, MODE_OAM_SCAN);
    endtask

    task automatic test_holding_register();
        issue_request(REQ_CPU_READ, ADDR_OAM_LO, 8'h00, MODE_DRAWING);
        issue_request(REQ_CPU_READ, ADDR_LY, 8'h00, 2'd0);
        issue_request(REQ_CPU_READ, ADDR_VRAM_HI, 8'h00, MODE_DRAWING);
        issue_request(REQ_ROM_LOAD, ADDR_VRAM_LO - 16'd1, 8'hA5, MODE_DRAWING);
        issue_request(REQ_CPU_READ, ADDR_VRAM_LO - 16'd1, 8'h00, 2'd1);
        issue_request(REQ_CPU_READ, ADDR_PAL_LO, 8'h00, MODE_DRAWING);
        issue_request(REQ_CPU_READ, 16'hC000, 8'h00, 2'd0);
        issue_request(REQ_CPU_READ, ADDR_OAM_HI, 8'h00, MODE_OAM_SCAN);
    endtask

    task automatic test_write_rules();
        issue_request(REQ_CPU_WRITE, 16'h0000, 8'hFF, 2'd0);
        issue_request(REQ_CPU_WRITE, ADDR_LY, 8'hFF, 2'd1);
        issue_request(REQ_CPU_WRITE, ADDR_DIV, 8'hFF, 2'd0);
        issue_request(REQ_PPU_READ, ADDR_DIV, 8'h00, 2'd0);
        issue_request(REQ_CPU_WRITE, ADDR_PAL_HI, 8'h81, MODE_DRAWING);
        issue_request(REQ_CPU_WRITE, ADDR_OAM_HI, 8'h7E, MODE_OAM_SCAN);
        issue_request(REQ_CPU_WRITE, ADDR_VRAM_LO, 8'h5A, MODE_OAM_SCAN);
        issue_request(REQ_CPU_WRITE, 16'hFFFF, 8'hFF, MODE_DRAWING);
    endtask

    task automatic test_oam_dma();
        issue_request(REQ_CPU_WRITE, ADDR_DMA, 8'h80, MODE_DRAWING);
        issue_request(REQ_PPU_READ, ADDR_OAM_LO, 8'h00, MODE_DRAWING);
        issue_request(REQ_CPU_WRITE, ADDR_DMA, IO_PAGE, MODE_OAM_SCAN);
        issue_request(REQ_PPU_READ, ADDR_OAM_LO + 16'h0046, 8'h00, 2'd0);
        issue_request(REQ_PPU_READ, ADDR_OAM_HI, 8'h00, 2'd1);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count)
            issue_request(2'($urandom_range(0, 3)), pick_address(), 8'($urandom),
                          2'($urandom_range(0, 3)));
    endtask

    // Fill part of a source page, copy it into OAM, then read it back.
    task automatic test_dma_sequences(input int count);
        logic [7:0] page;
        repeat (count)
        begin
            case ($urandom_range(0, 5))
                0:       page = 8'($urandom);
                1:       page = 8'($urandom_range(8'h00, 8'h7F));
                2:       page = 8'($urandom_range(8'h80, 8'h97));
                3:       page = 8'($urandom_range(8'hC0, 8'hDF));
                4:       page = 8'hFE;
                default: page = IO_PAGE;
            endcase
            repeat ($urandom_range(1, 4))
                issue_request(REQ_ROM_LOAD, {page, 8'($urandom_range(0, DMA_LENGTH - 1))},
                              8'($urandom), 2'($urandom_range(0, 3)));
            if ($urandom_range(0, 4) == 0)
                test_random_traffic(1);
            issue_request(REQ_CPU_WRITE, ADDR_DMA, page, 2'($urandom_range(0, 3)));
            repeat ($urandom_range(1, 3))
                issue_request($urandom_range(0, 1) ? REQ_PPU_READ : REQ_CPU_READ,
                              ADDR_OAM_LO + 16'($urandom_range(0, DMA_LENGTH - 1)),
                              8'($urandom), 2'($urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        sender_idles = 1'b1;
        error_count  = 0;
        report_count = 0;
        apply_reset();
        test_reset_contents();
        test_holding_register();
        test_write_rules();
        test_oam_dma();
        sender_idles = 1'b0;
        test_random_traffic(150);
        sender_idles = 1'b1;
        test_dma_sequences(15);
        wait_results_drained();
        test_random_traffic(250);
        test_dma_sequences(20);
        wait_results_drained();
        repeat (DMA_LENGTH + 8) @(negedge clk);
        if (expected_results.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
